// File: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// First-fit allocator package
// Item types, status codes and register indexes shared by the allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [15:0] free_offset;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] payload_offset;
    } out_item_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic REG_POOL_BYTES  = 1'b0;
    localparam logic REG_POOL_ENABLE = 1'b1;

endpackage

// File: design/first_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// First-fit block allocator
// Address-ordered block list in a slot memory, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Each list entry walked takes a read state and a check state; split or merge
// updates add reads and writes on the slot memory's separate ports, and a
// finish state presents the result. One item is handled at a time.
// Reset: S_INIT sets up the head slot, then the block is ready. A write to
// pool_bytes reinitialises the list in the cycle of the write.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 2048,
    parameter int HEADER_BYTES = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_we,
    input  logic      cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SW = $clog2(MAX_BLOCKS);
    localparam int LW = SW + 1;
    localparam logic [LW-1:0] NIL = '1;
    localparam logic [LW-1:0] MAXL = LW'(MAX_BLOCKS);
    localparam logic [LW-1:0] TOP_COUNT = LW'(MAX_BLOCKS - 1);
    localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
    localparam logic [16:0] HDR17 = 17'(HEADER_BYTES);

    typedef struct packed {
        logic [15:0]   start;
        logic [15:0]   len;
        logic          taken;
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
    } entry_t;

    typedef enum logic [12:0] {
        S_INIT  = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_WRD   = 13'b0000000000100,
        S_WCHK  = 13'b0000000001000,
        S_SPLIT = 13'b0000000010000,
        S_LRD   = 13'b0000000100000,
        S_LWR   = 13'b0000001000000,
        S_CUR   = 13'b0000010000000,
        S_PRD   = 13'b0000100000000,
        S_PCHK  = 13'b0001000000000,
        S_NRD   = 13'b0010000000000,
        S_NCHK  = 13'b0100000000000,
        S_FIN   = 13'b1000000000000
    } state_t;

    entry_t        slot_mem [MAX_BLOCKS];
    logic [SW-1:0] stack_mem [MAX_BLOCKS];
    entry_t        mem_rd;
    logic [SW-1:0] stk_rd;

    logic          mem_we;
    logic [SW-1:0] mem_waddr, mem_raddr;
    entry_t        mem_wdata;
    logic          stk_we;
    logic [SW-1:0] stk_waddr, stk_raddr, stk_wdata;

    state_t        state_reg, state_next, ret_reg, ret_next;
    logic [LW-1:0] count_reg, count_next, lw_reg, lw_next;
    logic [15:0]   pool_bytes_reg, pool_bytes_next;
    logic          pool_enable_reg, pool_enable_next;
    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    logic [SW-1:0] cur_reg, cur_next, aux_reg, aux_next;
    logic [SW-1:0] fix_slot_reg, fix_slot_next, fix_val_reg, fix_val_next;
    entry_t        ent_reg, ent_next;
    logic          mode_reg, mode_next, fresh_reg, fresh_next;
    logic [15:0]   req_reg, req_next, off_reg, off_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [15:0]   res_off_reg, res_off_next;

    function automatic entry_t head_entry(input logic [15:0] pool);
        entry_t e;
        e.start = '0;
        e.len   = (pool > HDR16) ? pool - HDR16 : '0;
        e.taken = 1'b0;
        e.nxt   = NIL;
        e.prv   = NIL;
        return e;
    endfunction

    function automatic logic link_ok(input logic [LW-1:0] l);
        return l < MAXL;
    endfunction

    always_comb
    begin
        entry_t        e;
        entry_t        w;
        logic [SW-1:0] ns;
        logic [LW-1:0] dec;

        state_next       = state_reg;
        ret_next         = ret_reg;
        count_next       = count_reg;
        lw_next          = lw_reg;
        pool_bytes_next  = pool_bytes_reg;
        pool_enable_next = pool_enable_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        cur_next         = cur_reg;
        aux_next         = aux_reg;
        fix_slot_next    = fix_slot_reg;
        fix_val_next     = fix_val_reg;
        ent_next         = ent_reg;
        mode_next        = mode_reg;
        fresh_next       = fresh_reg;
        req_next         = req_reg;
        off_next         = off_reg;
        res_status_next  = res_status_reg;
        res_off_next     = res_off_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_reg;
        mem_wdata        = ent_reg;
        mem_raddr        = cur_reg;
        stk_we           = 1'b0;
        stk_waddr        = count_reg[SW-1:0];
        stk_wdata        = aux_reg;
        dec              = count_reg - LW'(1);
        stk_raddr        = dec[SW-1:0];
        e                = mem_rd;
        w                = mem_rd;
        ns               = fresh_reg ? count_reg[SW-1:0] + SW'(1) : stk_rd;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = head_entry(pool_bytes_reg);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next    = in_data.mode;
                    req_next     = in_data.request_bytes;
                    off_next     = in_data.free_offset;
                    res_off_next = '0;
                    cur_next     = '0;
                    if (!pool_enable_reg || pool_bytes_reg <= HDR16 ||
                        (in_data.mode == MODE_ALLOC && in_data.request_bytes == '0))
                    begin
                        res_status_next = ST_BAD;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WRD;
                    end
                end
            end
            S_WRD:
            begin
                state_next = S_WCHK;
            end
            S_WCHK:
            begin
                ent_next = e;
                if (mode_reg == MODE_ALLOC)
                begin
                    if (!e.taken && e.len >= req_reg)
                    begin
                        res_status_next = ST_OK;
                        res_off_next    = e.start + HDR16;
                        ent_next.taken  = 1'b1;
                        if ({1'b0, e.len} >= {1'b0, req_reg} + HDR17 && count_reg != '0)
                        begin
                            count_next = dec;
                            fresh_next = dec < lw_reg;
                            if (dec < lw_reg)
                            begin
                                lw_next = dec;
                            end
                            state_next = S_SPLIT;
                        end
                        else
                        begin
                            state_next = S_CUR;
                        end
                    end
                    else if (link_ok(e.nxt))
                    begin
                        cur_next   = e.nxt[SW-1:0];
                        state_next = S_WRD;
                    end
                    else
                    begin
                        res_status_next = ST_NO_FIT;
                        state_next      = S_FIN;
                    end
                end
                else
                begin
                    if ({1'b0, e.start} + HDR17 == {1'b0, off_reg})
                    begin
                        if (!e.taken)
                        begin
                            res_status_next = ST_IGNORED;
                            state_next      = S_FIN;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            ent_next.taken  = 1'b0;
                            if (link_ok(e.prv))
                            begin
                                aux_next   = e.prv[SW-1:0];
                                state_next = S_PRD;
                            end
                            else
                            begin
                                state_next = S_NRD;
                            end
                        end
                    end
                    else if (link_ok(e.nxt))
                    begin
                        cur_next   = e.nxt[SW-1:0];
                        state_next = S_WRD;
                    end
                    else
                    begin
                        res_status_next = ST_IGNORED;
                        state_next      = S_FIN;
                    end
                end
            end
            S_SPLIT:
            begin
                mem_we          = 1'b1;
                mem_waddr       = ns;
                mem_wdata.start = ent_reg.start + HDR16 + req_reg;
                mem_wdata.len   = ent_reg.len - req_reg - HDR16;
                mem_wdata.taken = 1'b0;
                mem_wdata.prv   = {1'b0, cur_reg};
                mem_wdata.nxt   = ent_reg.nxt;
                ent_next.nxt    = {1'b0, ns};
                ent_next.len    = req_reg;
                if (link_ok(ent_reg.nxt))
                begin
                    fix_slot_next = ent_reg.nxt[SW-1:0];
                    fix_val_next  = ns;
                    ret_next      = S_CUR;
                    state_next    = S_LRD;
                end
                else
                begin
                    state_next = S_CUR;
                end
            end
            S_LRD:
            begin
                mem_raddr  = fix_slot_reg;
                state_next = S_LWR;
            end
            S_LWR:
            begin
                w.prv      = {1'b0, fix_val_reg};
                mem_we     = 1'b1;
                mem_waddr  = fix_slot_reg;
                mem_wdata  = w;
                state_next = ret_reg;
            end
            S_CUR:
            begin
                mem_we     = 1'b1;
                state_next = S_FIN;
            end
            S_PRD:
            begin
                mem_raddr  = aux_reg;
                state_next = S_PCHK;
            end
            S_PCHK:
            begin
                state_next = S_NRD;
                if (!e.taken)
                begin
                    if (count_reg < MAXL)
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = cur_reg;
                        count_next = count_reg + LW'(1);
                    end
                    w.len    = e.len + ent_reg.len + HDR16;
                    w.nxt    = ent_reg.nxt;
                    ent_next = w;
                    cur_next = aux_reg;
                    if (link_ok(ent_reg.nxt))
                    begin
                        fix_slot_next = ent_reg.nxt[SW-1:0];
                        fix_val_next  = aux_reg;
                        ret_next      = S_NRD;
                        state_next    = S_LRD;
                    end
                end
            end
            S_NRD:
            begin
                if (link_ok(ent_reg.nxt))
                begin
                    mem_raddr  = ent_reg.nxt[SW-1:0];
                    aux_next   = ent_reg.nxt[SW-1:0];
                    state_next = S_NCHK;
                end
                else
                begin
                    state_next = S_CUR;
                end
            end
            S_NCHK:
            begin
                state_next = S_CUR;
                if (!e.taken)
                begin
                    if (count_reg < MAXL)
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = aux_reg;
                        count_next = count_reg + LW'(1);
                    end
                    ent_next.len = ent_reg.len + e.len + HDR16;
                    ent_next.nxt = e.nxt;
                    if (link_ok(e.nxt))
                    begin
                        fix_slot_next = e.nxt[SW-1:0];
                        fix_val_next  = cur_reg;
                        ret_next      = S_CUR;
                        state_next    = S_LRD;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = res_status_reg;
                    out_data_next.payload_offset = res_off_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL_BYTES:
                begin
                    pool_bytes_next = cfg_data;
                    count_next      = TOP_COUNT;
                    lw_next         = TOP_COUNT;
                    mem_we          = 1'b1;
                    mem_waddr       = '0;
                    mem_wdata       = head_entry(cfg_data);
                end
                REG_POOL_ENABLE:
                begin
                    pool_enable_next = cfg_data[0];
                end
                default:
                begin
                    pool_enable_next = pool_enable_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        mem_rd <= slot_mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_rd <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            ret_reg         <= S_CUR;
            count_reg       <= TOP_COUNT;
            lw_reg          <= TOP_COUNT;
            pool_bytes_reg  <= '0;
            pool_enable_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            count_reg       <= count_next;
            lw_reg          <= lw_next;
            pool_bytes_reg  <= pool_bytes_next;
            pool_enable_reg <= pool_enable_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        cur_reg        <= cur_next;
        aux_reg        <= aux_next;
        fix_slot_reg   <= fix_slot_next;
        fix_val_reg    <= fix_val_next;
        ent_reg        <= ent_next;
        mode_reg       <= mode_next;
        fresh_reg      <= fresh_next;
        req_reg        <= req_next;
        off_reg        <= off_next;
        res_status_reg <= res_status_next;
        res_off_reg    <= res_off_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= TOP_COUNT)
        else $error("Spare slot count exceeds the slot range.");
    assert property (@(posedge clk) disable iff (!rst_n) lw_reg <= count_reg)
        else $error("Stack low-water mark above the spare count.");
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("Result item raised outside the finish state.");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.status != ST_OK |-> out_data_reg.payload_offset == '0)
        else $error("Failed request carries a non-zero offset.");

endmodule
